// ===== hw/rtl/itoa_pkg.sv =====
// itoa_pkg: shared types, constants and helpers for the integer to ascii radix unit
// no dependencies; imported by itoa_divider and integer_to_ascii_radix_unit
package itoa_pkg;

   // default operand width and csr geometry
   localparam int VALUE_WIDTH_DEFAULT = 64;
   localparam int CSR_ADDR_WIDTH      = 3;
   localparam int CSR_DATA_WIDTH      = 32;
   localparam int RADIX_WIDTH         = 6;

   // register indexes (paddr[2])
   localparam logic REG_CONVERSION_BASE = 1'b0;

   // radix limits and reset value
   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN     = 6'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX     = 6'd36;
   localparam logic [RADIX_WIDTH-1:0] RADIX_DECIMAL = 6'd10;

   // character codes
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_A_LOWER = 8'h61;
   localparam logic [7:0] CHAR_MINUS   = 8'h2d;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_READ,
      S_LOAD,
      S_SEND
   } itoa_state_type;

   // status from the shared divider
   typedef struct packed {
      logic done;
      logic quot_zero;
   } itoa_div_status_type;

   // clamp a raw radix setting to 2..36
   function automatic logic [RADIX_WIDTH-1:0] effective_radix(
      input logic [RADIX_WIDTH-1:0] raw
   );
      logic [RADIX_WIDTH-1:0] r;
      begin
         r = raw;
         if (raw < RADIX_MIN) r = RADIX_MIN;
         else if (raw > RADIX_MAX) r = RADIX_MAX;
         return r;
      end
   endfunction

   // digit value to ascii: 0-9 then a-z
   function automatic logic [7:0] digit_char(input logic [RADIX_WIDTH-1:0] d);
      logic [7:0] c;
      begin
         if (d < RADIX_DECIMAL) c = CHAR_ZERO + {2'b00, d};
         else c = CHAR_A_LOWER + {2'b00, d - RADIX_DECIMAL};
         return c;
      end
   endfunction

endpackage

// ===== hw/rtl/itoa_divider.sv =====
// itoa_divider: restoring divider, one quotient bit per cycle, small divisor
// depends on itoa_pkg
module itoa_divider
   import itoa_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [VALUE_WIDTH-1:0]     dividend,
   input  logic [RADIX_WIDTH-1:0]     divisor,
   output logic [VALUE_WIDTH-1:0]     quotient,
   output logic [RADIX_WIDTH-1:0]     remainder,
   output itoa_div_status_type        status
);

   localparam int CntWidth = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

   logic [VALUE_WIDTH-1:0] quot_ff, quot_in;
   logic [RADIX_WIDTH-1:0] rem_ff, rem_in;
   logic [RADIX_WIDTH-1:0] div_ff, div_in;
   logic [CntWidth-1:0]    cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [RADIX_WIDTH:0]   trial;
   logic [RADIX_WIDTH:0]   diff;
   logic                   fits;

   // one restoring step: shift in next dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, quot_ff[VALUE_WIDTH-1]};
      fits  = (trial >= {1'b0, div_ff});
      diff  = trial - {1'b0, div_ff};
   end

   // next state of the divider
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CntWidth'(VALUE_WIDTH - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[VALUE_WIDTH-2:0], fits};
         rem_in  = fits ? diff[RADIX_WIDTH-1:0] : trial[RADIX_WIDTH-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
   end

   assign quotient         = quot_ff;
   assign remainder        = rem_ff;
   assign status.done      = done_ff;
   assign status.quot_zero = (quot_ff == '0);

endmodule

// ===== hw/rtl/integer_to_ascii_radix_unit.sv =====
// integer_to_ascii_radix_unit: renders a signed integer as ascii text in radix 2..36
// depends on itoa_pkg and itoa_divider
//
// Usage: a request on req_ carries one signed value (low VALUE_WIDTH bits used).
// The rsp_ channel returns its characters one per response, most significant
// first, rsp_last_char set on the final one. In radix 10 a negative value
// starts with '-'; in other radices it prints as its unsigned bit pattern.
// The radix is the csr register at address 0 (values clamp to 2..36), reset 10.
// Sequence: digits come from a shared bit-serial divider and are written to a
// digit memory; characters are then read back through S_READ, S_LOAD and
// S_SEND, with S_SEND waiting out any stall on rsp_ready. req_ready is high
// only when idle, one request at a time.
// A stalled receiver holds the response register and the whole unit waits.
// Reset clears the sequencer and returns the radix to 10; no clearing pass.
module integer_to_ascii_radix_unit
   import itoa_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [63:0]        req_value_in,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_char_code,
   output logic                      rsp_last_char,
   // csr port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   localparam int AddrWidth  = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
   localparam int DepthWidth = $clog2(VALUE_WIDTH + 1);

   itoa_state_type         state_ff, state_in;
   logic [RADIX_WIDTH-1:0] radix_ff, radix_in;
   logic [RADIX_WIDTH-1:0] div_radix_ff, div_radix_in;
   logic                   neg_ff, neg_in;
   logic [DepthWidth-1:0]  depth_ff, depth_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             char_ff, char_in;
   logic                   last_ff, last_in;

   logic                   div_start;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic [VALUE_WIDTH-1:0] div_quotient;
   logic [RADIX_WIDTH-1:0] div_remainder;
   itoa_div_status_type    div_status;

   logic [RADIX_WIDTH-1:0] digit_mem [VALUE_WIDTH];
   logic                   mem_we;
   logic [AddrWidth-1:0]   mem_waddr;
   logic                   mem_re;
   logic [AddrWidth-1:0]   mem_raddr;
   logic [RADIX_WIDTH-1:0] mem_rdata_ff;

   logic [VALUE_WIDTH-1:0] raw_value;
   logic [VALUE_WIDTH-1:0] neg_value;
   logic [RADIX_WIDTH-1:0] req_radix;
   logic                   req_neg_dec;
   logic                   csr_write;

   // csr access
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_CONVERSION_BASE);
   assign radix_in  = csr_write ? pwdata[RADIX_WIDTH-1:0] : radix_ff;
   assign prdata    = (paddr[2] == REG_CONVERSION_BASE)
                      ? {{(CSR_DATA_WIDTH-RADIX_WIDTH){1'b0}}, radix_ff} : '0;

   // request decode: sign handling and radix clamp
   always_comb begin
      raw_value   = req_value_in[VALUE_WIDTH-1:0];
      neg_value   = ~raw_value + 1'b1;
      req_radix   = effective_radix(radix_ff);
      req_neg_dec = raw_value[VALUE_WIDTH-1] && (req_radix == RADIX_DECIMAL);
   end

   // shared divider
   itoa_divider #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_radix_in),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .status    (div_status)
   );

   // sequencer: next state and outputs
   always_comb begin
      state_in     = state_ff;
      div_radix_in = div_radix_ff;
      neg_in       = neg_ff;
      depth_in     = depth_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      div_start    = 1'b0;
      div_dividend = div_quotient;
      mem_we       = 1'b0;
      mem_waddr    = depth_ff[AddrWidth-1:0];
      mem_re       = 1'b0;
      mem_raddr    = AddrWidth'(depth_ff - 1'b1);
      req_ready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               div_radix_in = req_radix;
               neg_in       = req_neg_dec;
               depth_in     = '0;
               div_start    = 1'b1;
               div_dividend = req_neg_dec ? neg_value : raw_value;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               mem_we   = 1'b1;
               depth_in = depth_ff + 1'b1;
               if (!div_status.quot_zero) begin
                  div_start = 1'b1;
               end else if (neg_ff) begin
                  char_in      = CHAR_MINUS;
                  last_in      = 1'b0;
                  rsp_valid_in = 1'b1;
                  state_in     = S_SEND;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            mem_re   = 1'b1;
            depth_in = depth_ff - 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            char_in      = digit_char(mem_rdata_ff);
            last_in      = (depth_ff == '0);
            rsp_valid_in = 1'b1;
            state_in     = S_SEND;
         end
         S_SEND: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = last_ff ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         radix_ff     <= RADIX_DECIMAL;
         rsp_valid_ff <= 1'b0;
         depth_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         rsp_valid_ff <= rsp_valid_in;
         depth_ff     <= depth_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      div_radix_ff <= div_radix_in;
      neg_ff       <= neg_in;
      char_ff      <= char_in;
      last_ff      <= last_in;
   end

   // digit memory, least significant digit at address 0
   always_ff @(posedge clock) begin
      if (mem_we) digit_mem[mem_waddr] <= div_remainder;
      if (mem_re) mem_rdata_ff <= digit_mem[mem_raddr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last_char = last_ff;

   // no new request while a response is pending
   assert property (@(posedge clock) disable iff (reset) req_ready |-> !rsp_valid)
      else $error("request accepted while response pending");

   // divider only finishes while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset) div_status.done |-> state_ff == S_DIV)
      else $error("divider done outside divide phase");

   // digit count never exceeds the memory depth
   assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DepthWidth'(VALUE_WIDTH))
      else $error("digit count overflow");

   // last character only once all digits are drained
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_char |-> depth_ff == '0)
      else $error("last character with digits left");

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for integer_to_ascii_radix_unit: checks every character against a local predictor
// depends on itoa_pkg and the unit rtl; drives requests, the csr port and random rsp stalls
module testbench;
   import itoa_pkg::*;

   // csr addresses
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_BASE     = {REG_CONVERSION_BASE, 2'b00};
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_UNMAPPED = 3'd4;

   // ascii codes used by the predictor
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_LOWER = 8'h61;
   localparam logic [7:0] ASCII_MINUS = 8'h2d;

   localparam int IDLE_LIMIT = 40000;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } text_char_t;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [63:0]        req_value_in = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [7:0]                rsp_char_code;
   logic                      rsp_last_char;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   // predictor state: radix register and characters still owed
   logic [5:0]  radix_setting = RADIX_DECIMAL;
   text_char_t  expected_chars[$];
   int          error_count = 0;
   int          burst_left = 0;
   int          idle_cycles = 0;
   int          stall_tick = 0;
   int          stall_mode = 0;
   int          stall_hold = 0;
   logic        stall_level = 1'b0;

   integer_to_ascii_radix_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always #4 clock = ~clock;

   // clamp the radix setting into 2..36
   function automatic logic [63:0] active_radix();
      if (radix_setting < 6'd2) return 64'd2;
      if (radix_setting > 6'd36) return 64'd36;
      return {58'd0, radix_setting};
   endfunction

   function automatic logic [7:0] digit_ascii(input logic [63:0] d);
      if (d < 64'd10) return ASCII_ZERO + d[7:0];
      return ASCII_LOWER + (d[7:0] - 8'd10);
   endfunction

   // queue up the characters that one value should produce
   task automatic predict_text(input logic [63:0] value);
      logic [63:0] radix;
      logic [63:0] mag;
      logic [7:0]  digits [64];
      int          ndig;
      bit          neg_dec;
      text_char_t  c;
      radix   = active_radix();
      neg_dec = value[63] && (radix == 64'd10);
      mag     = neg_dec ? (~value + 64'd1) : value;
      ndig    = 0;
      do begin
         digits[ndig] = digit_ascii(mag % radix);
         ndig++;
         mag = mag / radix;
      end while (mag != 0 && ndig < 64);
      if (neg_dec) begin
         c.char_code = ASCII_MINUS;
         c.last_char = 1'b0;
         expected_chars.push_back(c);
      end
      for (int i = ndig - 1; i >= 0; i--) begin
         c.char_code = digits[i];
         c.last_char = (i == 0);
         expected_chars.push_back(c);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch: %s got 0x%0h want 0x%0h", what, got, want);
      error_count++;
   endtask

   // one request; the sender runs in bursts with random gaps
   task automatic send_value(input logic [63:0] value);
      req_valid    <= 1'b1;
      req_value_in <= value;
      do @(posedge clock); while (!req_ready);
      predict_text(value);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         burst_left = $urandom_range(0, 6);
      end
   endtask

   // stop sending and wait until every character has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_chars.size() != 0 || !req_ready);
   endtask

   // apb write: setup cycle then access cycle
   task automatic csr_write(input logic [CSR_ADDR_WIDTH-1:0] addr,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_BASE) radix_setting = data[5:0];
   endtask

   function automatic logic [63:0] random_value();
      logic [63:0] v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: v = 64'd0;
               1: v = 64'h8000_0000_0000_0000;
               2: v = 64'h7fff_ffff_ffff_ffff;
               3: v = '1;
               default: v = 64'd1;
            endcase
         end
         1, 2, 3: v = {$urandom, $urandom};
         default: begin
            v = {$urandom, $urandom} >> $urandom_range(0, 63);
            if ($urandom_range(0, 1) == 1) v = -v;
         end
      endcase
      return v;
   endfunction

   // decimal after reset: zero, signs and the extremes
   task automatic test_decimal_reset();
      send_value(64'd0);
      send_value(64'd1);
      send_value('1);
      send_value(64'd9);
      send_value(64'd10);
      send_value(64'h7fff_ffff_ffff_ffff);
      send_value(64'h8000_0000_0000_0000);
      send_value(-64'sd1234567890);
      wait_idle();
   endtask

   // radix extremes, clamping, upper write bits and an unmapped address
   task automatic test_radix_extremes();
      csr_write(ADDR_BASE, 32'd2);
      send_value(64'd0);
      send_value(64'd1);
      send_value('1);
      send_value(64'h8000_0000_0000_0000);
      send_value(64'h7fff_ffff_ffff_ffff);
      send_value(64'd5);
      wait_idle();
      csr_write(ADDR_BASE, 32'd36);
      send_value(64'd35);
      send_value(64'd36);
      send_value('1);
      send_value(64'h7fff_ffff_ffff_ffff);
      wait_idle();
      // below 2 acts as 2
      csr_write(ADDR_BASE, 32'd0);
      send_value(64'd5);
      wait_idle();
      csr_write(ADDR_BASE, 32'd1);
      send_value(64'd6);
      wait_idle();
      // above 36 acts as 36
      csr_write(ADDR_BASE, 32'd37);
      send_value(64'd35);
      wait_idle();
      csr_write(ADDR_BASE, 32'd63);
      send_value(64'd36);
      wait_idle();
      // only the low six bits count
      csr_write(ADDR_BASE, 32'hffff_ffd0);
      send_value(64'h0123_4567_89ab_cdef);
      send_value('1);
      wait_idle();
      // a write elsewhere leaves the radix alone
      csr_write(ADDR_UNMAPPED, 32'd3);
      send_value(64'd100);
      wait_idle();
   endtask

   // random values over several radix settings, with a full drain partway through and at the end of each phase
   task automatic test_random_values();
      int radix_plan [7];
      int pause_at;
      radix_plan = '{10, 16, 2, 36, 8, 0, 0};
      radix_plan[5] = $urandom_range(3, 35);
      radix_plan[6] = $urandom_range(0, 63);
      foreach (radix_plan[p]) begin
         csr_write(ADDR_BASE, radix_plan[p]);
         pause_at = $urandom_range(5, 25);
         for (int n = 0; n < 30; n++) begin
            if (n == pause_at) wait_idle();
            send_value(random_value());
         end
         wait_idle();
      end
   endtask

   // receiver stall pattern: always ready, coin flips, or runs of random length
   always @(posedge clock) begin
      stall_tick++;
      if (stall_tick % 300 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         default: begin
            if (stall_hold == 0) begin
               stall_level = ~stall_level;
               stall_hold  = $urandom_range(1, 15);
            end
            stall_hold--;
            rsp_ready <= stall_level;
         end
      endcase
   end

   // compare each accepted character with the oldest one owed
   always @(posedge clock) begin : check_chars
      text_char_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            report_mismatch("character with none owed", 64'(rsp_char_code), 64'd0);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_char_code !== want.char_code)
               report_mismatch("char_code", 64'(rsp_char_code), 64'(want.char_code));
            if (rsp_last_char !== want.last_char)
               report_mismatch("last_char", 64'(rsp_last_char), 64'(want.last_char));
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_decimal_reset();
      test_radix_extremes();
      test_random_values();
      wait_idle();
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
